@@ design/mss_pkg.sv @@
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants for the median-of-sample-set block
// Holds the payload structs of both channels and the size constants.
// ----------------------------------------------------------------------------
package mss_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_SAMPLES = 64;
	localparam int COUNT_BITS  = 7;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS:0] median_x2;
		logic [COUNT_BITS-1:0]       sample_count;
		logic                        overflow;
	} result_t;

endpackage

@@ design/median_of_sample_set_core.sv @@
// ----------------------------------------------------------------------------
// median_of_sample_set_core: streaming median by insertion sort
// Sorts a set of signed samples into a memory and returns twice its median.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : one sample per transfer, last marks the end of a set.
//   result channel : one transfer per set, carrying twice the median (the
//                    sum of the middle pair for an even count), the number
//                    of samples kept and an overflow flag.
// Each kept sample is inserted in ascending order into a single-port-read,
// single-port-write memory with a registered read port. Insertion walks
// down from the top of the set, one shifted entry per cycle; the shift
// loop runs through the memory read port.
// After the last sample two more reads fetch the middle pair; the result is
// registered in state ST_MB, after states ST_MRD and ST_MA.
// Samples that arrive with the memory full are dropped and flagged.
// The output register lets the next set start loading while a result waits;
// a new result waits in its final state until the previous one is taken.
// Reset clears the fill count, the overflow flag and the result valid; the
// memory is not cleared, as only entries below the fill count are read.
// ----------------------------------------------------------------------------
module median_of_sample_set_core #(
	parameter int MAX_SAMPLES = mss_pkg::MAX_SAMPLES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  mss_pkg::item_t  item,
	output logic            result_valid,
	input  logic            result_ready,
	output mss_pkg::result_t result
);

	localparam int SB    = mss_pkg::SAMPLE_BITS;
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_PLACE = 3'd2;
	localparam logic [2:0] ST_MRD   = 3'd3;
	localparam logic [2:0] ST_MA    = 3'd4;
	localparam logic [2:0] ST_MB    = 3'd5;

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       pos_q;
	logic                   drop_q;
	logic signed [SB-1:0]   v_q;
	logic                   last_q;
	logic signed [SB-1:0]   a_q;
	logic signed [SB-1:0]   rd_q;
	logic                   rv_q;
	mss_pkg::result_t       res_q;

	logic signed [SB-1:0]   sample_store [MAX_SAMPLES];

	logic                   we;
	logic [AW-1:0]          wa;
	logic signed [SB-1:0]   wd;
	logic [AW-1:0]          ra;
	logic                   accept;
	logic                   full;
	logic [CNT_W-1:0]       half;
	logic [CNT_W-1:0]       pos_m1;
	logic [CNT_W-1:0]       pos_m2;
	logic [CNT_W-1:0]       cnt_m1;
	logic [CNT_W-1:0]       half_m1;
	logic                   greater;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign full         = (count_q == CNT_W'(MAX_SAMPLES));
	assign half         = count_q >> 1;
	assign half_m1      = half - CNT_W'(1);
	assign pos_m1       = pos_q - CNT_W'(1);
	assign pos_m2       = pos_q - CNT_W'(2);
	assign cnt_m1       = count_q - CNT_W'(1);
	assign greater      = (rd_q > v_q);
	assign result_valid = rv_q;
	assign result       = res_q;

	// Memory port control
	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = v_q;
		ra = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (count_q == '0) begin
					we = accept;
					wd = item.sample;
				end else begin
					ra = cnt_m1[AW-1:0];
				end
			end
			ST_SHIFT: begin
				we = 1'b1;
				wa = pos_q[AW-1:0];
				if (greater) begin
					// move the larger entry up one place and look one lower
					wd = rd_q;
					ra = pos_m2[AW-1:0];
				end
			end
			ST_PLACE: begin
				we = 1'b1;
			end
			ST_MRD: begin
				ra = count_q[0] ? half[AW-1:0] : half_m1[AW-1:0];
			end
			ST_MA: begin
				ra = half[AW-1:0];
			end
			ST_MB: begin
				// keep reading the upper middle entry while the result waits
				ra = half[AW-1:0];
			end
			default: begin
				ra = '0;
			end
		endcase
	end

	// Sample memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			sample_store[wa] <= wd;
		end
		rd_q <= sample_store[ra];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q    <= item.sample;
			last_q <= item.last;
			pos_q  <= count_q;
		end else if (state_q == ST_SHIFT) begin
			pos_q <= pos_m1;
		end
		if (state_q == ST_MA) begin
			a_q <= rd_q;
		end
		if (state_q == ST_MB && (!rv_q || result_ready)) begin
			res_q.median_x2    <= {a_q[SB-1], a_q} + {rd_q[SB-1], rd_q};
			res_q.sample_count <= mss_pkg::COUNT_BITS'(count_q);
			res_q.overflow     <= drop_q;
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			drop_q  <= 1'b0;
			rv_q    <= 1'b0;
		end else begin
			// drop the valid once taken, unless a new result replaces it
			if (rv_q && result_ready && state_q != ST_MB) begin
				rv_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full) begin
							// drop the sample, keep the set
							drop_q <= 1'b1;
							if (item.last) begin
								state_q <= ST_MRD;
							end
						end else if (count_q == '0) begin
							count_q <= CNT_W'(1);
							if (item.last) begin
								state_q <= ST_MRD;
							end
						end else begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (greater) begin
						if (pos_q == CNT_W'(1)) begin
							state_q <= ST_PLACE;
						end
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= last_q ? ST_MRD : ST_IDLE;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= last_q ? ST_MRD : ST_IDLE;
				end
				ST_MRD: begin
					state_q <= ST_MA;
				end
				ST_MA: begin
					state_q <= ST_MB;
				end
				ST_MB: begin
					// hold until the output register is free
					if (!rv_q || result_ready) begin
						rv_q    <= 1'b1;
						count_q <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/mss_checker.sv @@
// ----------------------------------------------------------------------------
// mss_port_props: port-level checks for the median-of-sample-set block
// Watches the result channel of median_of_sample_set_core, bound into it.
// ----------------------------------------------------------------------------
module mss_port_props (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_ready,
	input mss_pkg::result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.sample_count != '0 &&
			result.sample_count <= mss_pkg::COUNT_BITS'(mss_pkg::MAX_SAMPLES))
		else $error("sample count out of range");

	a_odd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sample_count[0] |-> !result.median_x2[0])
		else $error("odd count gives odd median_x2");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflow |->
			result.sample_count == mss_pkg::COUNT_BITS'(mss_pkg::MAX_SAMPLES))
		else $error("overflow without a full set");

endmodule

bind median_of_sample_set_core mss_port_props u_mss_port_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
